// ----- design/tkas_pkg.sv -----
// Shared constants, key codes and field layout for the two-key autorepeat selector.
package tkas_pkg;

    localparam int COUNT_WIDTH = 8;
    localparam int HOLD_W      = COUNT_WIDTH + 1;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = 5;

    localparam logic [HOLD_W-1:0] HOLD_MAX  = '1;
    localparam logic [CNT_W-1:0]  MAX_SLOTS = 5'd16;

    localparam logic [7:0] RST_DELAY  = 8'd20;
    localparam logic [7:0] RST_PERIOD = 8'd5;
    localparam logic [4:0] RST_SLOTS  = 5'd9;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_DELAY  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_SLOTS  = 2'd2;

    localparam logic signed [1:0] DIR_NONE  = 2'sd0;
    localparam logic signed [1:0] DIR_RIGHT = 2'sd1;
    localparam logic signed [1:0] DIR_LEFT  = -2'sd1;

    typedef enum logic [1:0] {
        KEY_NONE  = 2'd0,
        KEY_LEFT  = 2'd1,
        KEY_RIGHT = 2'd2
    } t_key;

    typedef struct packed {
        logic                     changed;
        logic [SLOT_W-1:0]        selection;
        logic signed [1:0]        direction;
    } t_result;

endpackage

// ----- design/two_key_autorepeat_selector.sv -----
// Top level: typematic left/right key repeat that steps a wrapping slot selection.
//
// Usage:
//   Slave stream: one word per scan frame, tdata = down_left, down_right,
//   held_left, held_right (bits 0..3), upper bits zero.
//   Master stream: one word per input word, tdata = direction (signed, bits 1:0),
//   selection (bits 5:2), changed (bit 6), bit 7 zero.
//   APB port: repeat_delay at 0x0, repeat_period at 0x4, slot_count at 0x8;
//   pready is always high, reads return the stored values.
// Timing:
//   An accepted word lands in an input register; the key logic and slot step then
//   run in one short combinational pass into the result register, which raises
//   tvalid. One word per cycle is sustained while the receiver keeps tready high.
// Reset:
//   Synchronous active-low reset empties both registers, clears the key state and
//   the selection, and loads delay 20, period 5, slot count 9.
// Stall:
//   While the receiver holds tready low the result holds; the input register
//   still takes one more word, then s_axis_tready drops until the result moves.
module two_key_autorepeat_selector
    import tkas_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // down_left, down_right, held_left, held_right
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // direction[1:0], selection[5:2], changed[6]

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [7:0]        r_delay;
    logic [7:0]        r_period;
    logic [CNT_W-1:0]  r_slots;

    t_key              r_active, n_active;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [COUNT_WIDTH-1:0] r_phase, n_phase;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic              r_in_valid;
    logic [3:0]        r_in_data;
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic              load_out;
    logic              fire;
    logic              cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign load_out = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || load_out;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    always_comb begin
        unique case (paddr[3:2])
            REG_DELAY:  prdata = {24'd0, r_delay};
            REG_PERIOD: prdata = {24'd0, r_period};
            REG_SLOTS:  prdata = {27'd0, r_slots};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= RST_DELAY;
            r_period <= RST_PERIOD;
            r_slots  <= RST_SLOTS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DELAY:  r_delay  <= pwdata[7:0];
                REG_PERIOD: r_period <= pwdata[7:0];
                REG_SLOTS:  r_slots  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic                   dl, dr, hl, hr, held;
        logic [HOLD_W-1:0]      f;
        logic [COUNT_WIDTH-1:0] period, p;
        logic [COUNT_WIDTH:0]   p_inc;
        dl = r_in_data[0];
        dr = r_in_data[1];
        hl = r_in_data[2];
        hr = r_in_data[3];
        held     = 1'b0;
        f        = '0;
        p        = '0;
        p_inc    = '0;
        n_active = r_active;
        n_hold   = r_hold;
        n_phase  = r_phase;
        fire     = 1'b0;
        period   = (r_period == '0) ? COUNT_WIDTH'(1) : r_period;
        if (dl && dr) begin
            n_active = KEY_NONE;
            n_hold   = '0;
            n_phase  = '0;
        end else begin
            if (dl || dr) begin
                n_active = dl ? KEY_LEFT : KEY_RIGHT;
                n_hold   = '0;
                n_phase  = '0;
            end
            held = (n_active == KEY_LEFT) ? hl : hr;
            if (n_active != KEY_NONE) begin
                if (n_hold != '0 && !held) begin
                    n_active = KEY_NONE;
                    n_hold   = '0;
                    n_phase  = '0;
                end else begin
                    f = n_hold;
                    if (n_hold != HOLD_MAX) begin
                        n_hold = n_hold + 1'b1;
                    end
                    fire = (f == '0);
                    if (f >= {1'b0, r_delay}) begin
                        p = (n_phase >= period) ? '0 : n_phase;
                        if (f != '0) begin
                            fire = (p == '0);
                        end
                        p_inc   = {1'b0, p} + 1'b1;
                        n_phase = (p_inc >= {1'b0, period}) ? '0 : p_inc[COUNT_WIDTH-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        logic [CNT_W-1:0]  count, last;
        logic [SLOT_W-1:0] s;
        count  = (r_slots > MAX_SLOTS) ? MAX_SLOTS : r_slots;
        last   = count - 1'b1;
        n_slot = r_slot;
        s      = ({1'b0, r_slot} >= count) ? last[SLOT_W-1:0] : r_slot;
        if (fire && count != '0) begin
            if (n_active == KEY_RIGHT) begin
                n_slot = ({1'b0, s} + 1'b1 == count) ? '0 : s + 1'b1;
            end else begin
                n_slot = (s == '0) ? last[SLOT_W-1:0] : s - 1'b1;
            end
        end
        n_out.direction = !fire ? DIR_NONE : ((n_active == KEY_RIGHT) ? DIR_RIGHT : DIR_LEFT);
        n_out.selection = n_slot;
        n_out.changed   = (n_slot != r_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= KEY_NONE;
            r_hold      <= '0;
            r_phase     <= '0;
            r_slot      <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (load_out) begin
                r_in_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= r_in_valid;
            end
            if (load_out && r_in_valid) begin
                r_active <= n_active;
                r_hold   <= n_hold;
                r_phase  <= n_phase;
                r_slot   <= n_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata[3:0];
        end
        if (load_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- design/tkas_checker.sv -----
// Port-level checks for the two-key autorepeat selector, bound to the top level.
module tkas_checker
    import tkas_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_change_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[1:0] != DIR_NONE)
        else $error("selection changed without a fire");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10 && m_axis_tdata[7] == 1'b0)
        else $error("bad direction code or pad bit");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind two_key_autorepeat_selector tkas_checker u_tkas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
